[rtl/csvs_pkg.sv]
package csvs_pkg;

  localparam int unsigned COLUMN_BUFFER_BYTES = 16384;
  localparam int unsigned LINE_CAP = 16380;
  localparam int unsigned COLUMN_LIMIT =
    ((COLUMN_BUFFER_BYTES < LINE_CAP) ? COLUMN_BUFFER_BYTES : LINE_CAP) - 1;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 14;
  localparam int unsigned TALLY_W = 16;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // A byte arriving with this many bytes already in the column overflows it.
  localparam logic [CNT_W-1:0] OVF_RAW = CNT_W'(COLUMN_LIMIT - 1);

  localparam logic [BYTE_W-1:0] CH_NL  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'd32;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'd9;

  localparam logic [BYTE_W-1:0] SEP_RST = 8'd44;
  localparam logic [BYTE_W-1:0] CMT_RST = 8'd35;

  typedef enum logic [1:0] {
    REG_TRIM_ENABLE    = 2'd0,
    REG_SEPARATOR_CHAR = 2'd1,
    REG_COMMENT_ENABLE = 2'd2,
    REG_COMMENT_CHAR   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic              trim_enable;
    logic [BYTE_W-1:0] separator_char;
    logic              comment_enable;
    logic [BYTE_W-1:0] comment_char;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_input;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic [CNT_W-1:0]   byte_offset;
    logic               column_done;
    logic [CNT_W-1:0]   column_length;
    logic               line_done;
    logic [TALLY_W-1:0] line_columns;
    logic               overflow;
    logic               stream_end;
  } res_t;

  typedef struct packed {
    logic               line_active;
    logic               before_first_text;
    logic               skipping_comment;
    logic               collapsing_blanks;
    logic               discarding_line;
    logic [CNT_W-1:0]   raw_count;
    logic [CNT_W-1:0]   kept_count;
    logic [CNT_W-1:0]   text_end_mark;
    logic [TALLY_W-1:0] column_tally;
  } line_st_t;

  localparam line_st_t LINE_RST = '{
    line_active:       1'b0,
    before_first_text: 1'b1,
    skipping_comment:  1'b0,
    collapsing_blanks: 1'b0,
    discarding_line:   1'b0,
    raw_count:         '0,
    kept_count:        '0,
    text_end_mark:     '0,
    column_tally:      '0
  };

  localparam res_t RES_ZERO = '0;

endpackage

[rtl/csvs_ifs.sv]
interface csvs_in_if;
  logic                            valid;
  logic                            ready;
  logic [csvs_pkg::BYTE_W-1:0]     in_byte;
  logic                            end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface csvs_out_if;
  logic                            valid;
  logic                            ready;
  logic [csvs_pkg::BYTE_W-1:0]     out_byte;
  logic                            byte_valid;
  logic [csvs_pkg::CNT_W-1:0]      byte_offset;
  logic                            column_done;
  logic [csvs_pkg::CNT_W-1:0]      column_length;
  logic                            line_done;
  logic [csvs_pkg::TALLY_W-1:0]    line_columns;
  logic                            overflow;
  logic                            stream_end;

  modport source (
    output valid, out_byte, byte_valid, byte_offset, column_done, column_length,
           line_done, line_columns, overflow, stream_end,
    input  ready
  );
  modport sink (
    input  valid, out_byte, byte_valid, byte_offset, column_done, column_length,
           line_done, line_columns, overflow, stream_end,
    output ready
  );
endinterface

[rtl/csv_column_splitter.sv]
// Splits a byte stream into columns and lines, one result word per input word. A new
// input word is taken every cycle while the two-entry result buffer has room, so the
// sustained rate is one byte per clock; each result passes through the input
// register and then the result buffer. All per-byte work is a single pass of
// compare-and-increment logic on the line state between these two registers.
// Registers sit at byte addresses 0x0 (trim enable), 0x4 (separator), 0x8 (comment
// enable) and 0xC (comment byte); write them only while the splitter is idle.
module csv_column_splitter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csvs_pkg::PADDR_W-1:0] paddr,
  input  logic [csvs_pkg::PDATA_W-1:0] pwdata,
  output logic [csvs_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  csvs_in_if.sink                      in_i,
  csvs_out_if.source                   out_o
);

  csvs_pkg::cfg_t cfg;
  csvs_pkg::in_t  in_data;
  csvs_pkg::res_t core_res;
  csvs_pkg::res_t out_res;
  logic           res_push;
  logic           buf_ready;

  assign in_data.in_byte      = in_i.in_byte;
  assign in_data.end_of_input = in_i.end_of_input;

  csvs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csvs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_data),
    .res_push_o  (res_push),
    .res_ready_i (buf_ready),
    .res_o       (core_res)
  );

  csvs_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .data_i      (core_res),
    .ready_o     (buf_ready),
    .valid_o     (out_o.valid),
    .pop_ready_i (out_o.ready),
    .data_o      (out_res)
  );

  assign out_o.out_byte      = out_res.out_byte;
  assign out_o.byte_valid    = out_res.byte_valid;
  assign out_o.byte_offset   = out_res.byte_offset;
  assign out_o.column_done   = out_res.column_done;
  assign out_o.column_length = out_res.column_length;
  assign out_o.line_done     = out_res.line_done;
  assign out_o.line_columns  = out_res.line_columns;
  assign out_o.overflow      = out_res.overflow;
  assign out_o.stream_end    = out_res.stream_end;

endmodule

[rtl/csvs_regs.sv]
module csvs_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [csvs_pkg::PADDR_W-1:0]     paddr,
  input  logic [csvs_pkg::PDATA_W-1:0]     pwdata,
  output logic [csvs_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  output csvs_pkg::cfg_t                   cfg_o
);

  csvs_pkg::cfg_t     cfg_q;
  csvs_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = csvs_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trim_enable    <= 1'b0;
      cfg_q.separator_char <= csvs_pkg::SEP_RST;
      cfg_q.comment_enable <= 1'b0;
      cfg_q.comment_char   <= csvs_pkg::CMT_RST;
    end else if (wr_en) begin
      unique case (idx)
        csvs_pkg::REG_TRIM_ENABLE:    cfg_q.trim_enable    <= pwdata[0];
        csvs_pkg::REG_SEPARATOR_CHAR: cfg_q.separator_char <= pwdata[7:0];
        csvs_pkg::REG_COMMENT_ENABLE: cfg_q.comment_enable <= pwdata[0];
        csvs_pkg::REG_COMMENT_CHAR:   cfg_q.comment_char   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      csvs_pkg::REG_TRIM_ENABLE:    prdata = {31'd0, cfg_q.trim_enable};
      csvs_pkg::REG_SEPARATOR_CHAR: prdata = {24'd0, cfg_q.separator_char};
      csvs_pkg::REG_COMMENT_ENABLE: prdata = {31'd0, cfg_q.comment_enable};
      csvs_pkg::REG_COMMENT_CHAR:   prdata = {24'd0, cfg_q.comment_char};
      default: prdata = '0;
    endcase
  end

endmodule

[rtl/csvs_core.sv]
module csvs_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  csvs_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  csvs_pkg::in_t    in_data_i,
  output logic             res_push_o,
  input  logic             res_ready_i,
  output csvs_pkg::res_t   res_o
);

  csvs_pkg::in_t       in_q;
  logic                in_valid_q;
  csvs_pkg::line_st_t  st_q;
  csvs_pkg::line_st_t  st_d;
  csvs_pkg::res_t      res_d;

  logic                        push;
  logic                        go;
  logic                        lead_sp;
  logic [csvs_pkg::BYTE_W-1:0] c;
  logic                        is_sp;
  logic                        is_nl;
  logic [csvs_pkg::CNT_W-1:0]  len;
  logic [csvs_pkg::TALLY_W-1:0] tally_inc;

  assign push       = in_valid_q && res_ready_i;
  assign in_ready_o = !in_valid_q || res_ready_i;
  assign res_push_o = push;
  assign res_o      = res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= csvs_pkg::LINE_RST;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (push) begin
        in_valid_q <= 1'b0;
      end
      if (push) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  assign c         = in_q.in_byte;
  assign is_sp     = (c == csvs_pkg::CH_SP);
  assign is_nl     = (c == csvs_pkg::CH_NL);
  assign tally_inc = (st_q.column_tally == '1) ? st_q.column_tally
                                               : st_q.column_tally + 1'b1;
  assign lead_sp   = (st_q.kept_count == '0) && is_sp;

  always_comb begin
    res_d = csvs_pkg::RES_ZERO;
    st_d  = st_q;
    go    = 1'b0;
    len   = cfg_i.trim_enable ? st_q.text_end_mark : st_q.raw_count;
    if (in_q.end_of_input) begin
      res_d.stream_end = 1'b1;
      if (st_q.line_active) begin
        res_d.line_done    = 1'b1;
        res_d.line_columns = st_q.column_tally;
      end
      st_d = csvs_pkg::LINE_RST;
    end else begin
      st_d.line_active = 1'b1;
      if (st_q.discarding_line) begin
        if (is_nl) begin
          res_d.line_done    = 1'b1;
          res_d.line_columns = st_q.column_tally;
          st_d               = csvs_pkg::LINE_RST;
        end
      end else if (st_q.skipping_comment) begin
        if (is_nl) begin
          st_d.skipping_comment = 1'b0;
          st_d.raw_count        = '0;
          st_d.kept_count       = '0;
          st_d.text_end_mark    = '0;
        end
      end else begin
        go = 1'b1;
        if (st_q.collapsing_blanks) begin
          if (is_sp) begin
            go = 1'b0;
          end else begin
            st_d.collapsing_blanks = 1'b0;
          end
        end
        if (go && c == csvs_pkg::CH_CR) begin
          go = 1'b0;
        end
        if (go && st_q.before_first_text && !is_sp && c != csvs_pkg::CH_TAB) begin
          if (cfg_i.comment_enable && c == cfg_i.comment_char) begin
            st_d.skipping_comment = 1'b1;
            st_d.raw_count        = '0;
            st_d.kept_count       = '0;
            st_d.text_end_mark    = '0;
            go                    = 1'b0;
          end else begin
            st_d.before_first_text = 1'b0;
          end
        end
        if (go) begin
          if (c == cfg_i.separator_char || is_nl) begin
            if (is_nl && len == '0) begin
              res_d.line_done    = 1'b1;
              res_d.line_columns = st_q.column_tally;
              st_d               = csvs_pkg::LINE_RST;
            end else begin
              res_d.column_done   = 1'b1;
              res_d.column_length = len;
              st_d.column_tally   = tally_inc;
              if (is_nl) begin
                res_d.line_done    = 1'b1;
                res_d.line_columns = tally_inc;
                st_d               = csvs_pkg::LINE_RST;
              end else begin
                st_d.raw_count     = '0;
                st_d.kept_count    = '0;
                st_d.text_end_mark = '0;
                if (is_sp && cfg_i.trim_enable && cfg_i.separator_char == csvs_pkg::CH_SP) begin
                  st_d.collapsing_blanks = 1'b1;
                end
              end
            end
          end else if (st_q.raw_count >= csvs_pkg::OVF_RAW) begin
            res_d.overflow       = 1'b1;
            st_d.discarding_line = 1'b1;
          end else begin
            if (!cfg_i.trim_enable) begin
              res_d.out_byte    = c;
              res_d.byte_valid  = 1'b1;
              res_d.byte_offset = st_q.raw_count;
            end else if (!lead_sp) begin
              res_d.out_byte    = c;
              res_d.byte_valid  = 1'b1;
              res_d.byte_offset = st_q.kept_count;
            end
            st_d.raw_count = st_q.raw_count + 1'b1;
            if (!lead_sp) begin
              st_d.kept_count = st_q.kept_count + 1'b1;
              if (!is_sp) begin
                st_d.text_end_mark = st_q.kept_count + 1'b1;
              end
            end
          end
        end
      end
    end
  end

`ifndef SYNTH
  a_byte_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res_d.byte_valid |-> !res_d.column_done && !res_d.line_done)
    else $error("A stored byte coincides with a column or line end.");

  a_ovf_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res_d.overflow |=> st_q.discarding_line)
    else $error("Overflow did not start discarding the line.");

  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.kept_count <= st_q.raw_count && st_q.text_end_mark <= st_q.kept_count)
    else $error("Column counters out of order.");
`endif

endmodule

[rtl/csvs_obuf.sv]
module csvs_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  csvs_pkg::res_t   data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_ready_i,
  output csvs_pkg::res_t   data_o
);

  csvs_pkg::res_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("Result word written into a full buffer.");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("Result buffer count out of range.");
`endif

endmodule
